// ===== rtl/mm3_pkg.sv =====
`default_nettype none

package mm3_pkg;

  // Mixing constants
  localparam logic [31:0] MUL_A    = 32'hcc9e2d51;
  localparam logic [31:0] MUL_B    = 32'h1b873593;
  localparam logic [31:0] FOLD_ADD = 32'he6546b64;
  localparam logic [31:0] FIN_A    = 32'h85ebca6b;
  localparam logic [31:0] FIN_B    = 32'hc2b2ae35;

  localparam logic [2:0] WORD_BYTES = 3'd4;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Classified request as it travels from front to back
  typedef struct packed {
    logic [31:0] word;    // masked to the valid bytes
    logic [2:0]  nbytes;  // 0..4, counts toward the total
    logic        full;    // four bytes: mix and fold
    logic        last;    // finalize after this one
  } mm3_item_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MIX_A = 7'b0000010,
    ST_MIX_B = 7'b0000100,
    ST_FOLD  = 7'b0001000,
    ST_FIN_A = 7'b0010000,
    ST_FIN_B = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } mm3_state_e;

endpackage

`default_nettype wire

// ===== rtl/mm3_front.sv =====
`default_nettype none

module mm3_front import mm3_pkg::*; (
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        last_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output mm3_item_t        q_item_o
);

  logic [2:0]  nbytes;
  logic [31:0] mask;

  // Non-last words always count as four bytes; counts above four saturate.
  assign nbytes = (!last_i || (byte_count_i >= WORD_BYTES)) ? WORD_BYTES : byte_count_i;

  always_comb begin
    unique case (nbytes)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  assign in_ready_o      = !q_full_i;
  assign q_push_o        = in_valid_i && !q_full_i;
  assign q_item_o.word   = word_i & mask;
  assign q_item_o.nbytes = nbytes;
  assign q_item_o.full   = (nbytes == WORD_BYTES);
  assign q_item_o.last   = last_i;

endmodule

`default_nettype wire

// ===== rtl/mm3_queue.sv =====
`default_nettype none

module mm3_queue import mm3_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire mm3_item_t item_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output mm3_item_t      item_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  mm3_item_t           entries_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = entries_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mm3_back.sv =====
`default_nettype none

module mm3_back import mm3_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_empty_i,
  input  wire mm3_item_t   q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      hash_o
);

  mm3_state_e  state_q, state_d;
  mm3_item_t   cur_q, cur_d;
  logic [31:0] run_hash_q, run_hash_d;
  logic [31:0] total_q, total_d;
  logic [31:0] mul_q, mul_d;
  logic [31:0] hash_q, hash_d;
  logic        out_valid_q, out_valid_d;

  logic [31:0] mul_op, mul_k, mul_p;
  logic [31:0] fold_x, fold_r, fin_x;

  // Single shared multiplier, truncated to 32 bits
  assign mul_p = mul_op * mul_k;

  assign fold_x = run_hash_q ^ mul_q;
  assign fold_r = {fold_x[18:0], fold_x[31:19]};  // rotl 13
  assign fin_x  = run_hash_q ^ total_q;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    run_hash_d  = run_hash_q;
    total_d     = total_q;
    mul_d       = mul_q;
    hash_d      = hash_q;
    out_valid_d = out_valid_q;
    q_pop_o     = 1'b0;
    mul_op      = '0;
    mul_k       = MUL_A;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_item_i;
          state_d = ST_MIX_A;
        end
      end
      ST_MIX_A: begin
        mul_op  = cur_q.word;
        mul_k   = MUL_A;
        mul_d   = mul_p;
        state_d = ST_MIX_B;
      end
      ST_MIX_B: begin
        mul_op  = {mul_q[16:0], mul_q[31:17]};  // rotl 15
        mul_k   = MUL_B;
        mul_d   = mul_p;
        state_d = ST_FOLD;
      end
      ST_FOLD: begin
        // masked empty word scrambles to zero, so the xor is harmless
        total_d    = total_q + 32'(cur_q.nbytes);
        run_hash_d = cur_q.full ? ((fold_r << 2) + fold_r + FOLD_ADD)
                                : (run_hash_q ^ mul_q);
        state_d    = cur_q.last ? ST_FIN_A : ST_IDLE;
      end
      ST_FIN_A: begin
        mul_op  = fin_x ^ (fin_x >> 16);
        mul_k   = FIN_A;
        mul_d   = mul_p;
        state_d = ST_FIN_B;
      end
      ST_FIN_B: begin
        mul_op  = mul_q ^ (mul_q >> 13);
        mul_k   = FIN_B;
        mul_d   = mul_p;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          hash_d      = mul_q ^ (mul_q >> 16);
          out_valid_d = 1'b1;
          run_hash_d  = '0;
          total_d     = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_hash_q  <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_hash_q  <= run_hash_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    mul_q  <= mul_d;
    hash_q <= hash_d;
  end

  assign out_valid_o = out_valid_q;
  assign hash_o      = hash_q;

endmodule

`default_nettype wire

// ===== rtl/murmur3_32_stream_hash_unit.sv =====
// MurmurHash3 x86_32 (seed zero) over a stream of little-endian 32-bit words.
// Send one request per word: word_i holds four message bytes (first byte in
// bits 7:0), byte_count_i the valid bytes (0..4, only below four on the last
// word; 5..7 act as 4), last_i marks the end of the message. Exactly one hash
// comes out per request with last_i set, after which the running state is
// back to zero. The front masks the word and classifies it, then hands it
// through a small queue to the back, a sequencer around one shared 32x32
// multiplier. For each word the back pops it, does two multiplies and a
// fold; a last word adds two finalizer multiplies and the output load, which
// waits while a held hash has not been taken. The input side keeps taking
// requests while the queue has room, and the output register holds a
// finished hash while the next message is being processed.

`default_nettype none

module murmur3_32_stream_hash_unit import mm3_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH  // at least 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        last_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      hash_o
);

  logic      q_push, q_pop, q_full, q_empty;
  mm3_item_t q_in, q_out;

  // Front: byte-count saturation, masking, full/partial classification.
  mm3_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .word_i       (word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_item_o     (q_in)
  );

  // Decoupling queue between front and back.
  mm3_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_out),
    .empty_o (q_empty)
  );

  // Back: mix, fold, finalize and the output register.
  mm3_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hash_o      (hash_o)
  );

endmodule

`default_nettype wire

// ===== rtl/mm3_checker.sv =====
`default_nettype none

module mm3_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        last_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] hash_o
);

  logic [3:0] pending_q;
  logic       last_acc, out_acc;

  assign last_acc = in_valid_i && in_ready_o && last_i;
  assign out_acc  = out_valid_o && out_ready_i;

  // Messages whose last word went in but whose hash has not been taken yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (last_acc && !out_acc) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_acc && !last_acc) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hash_o))
    else $error("hash dropped or changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 4'd0)
    else $error("hash presented without a finished message");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

  a_in_ready_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(in_ready_o) && !$isunknown(out_valid_o))
    else $error("handshake output unknown");

endmodule

bind murmur3_32_stream_hash_unit mm3_checker u_mm3_checker (.*);

`default_nettype wire
